/* hdl/cpbu_pkg.sv */
// cpbu_pkg: shared types, codes, reset values and format helpers for the
// clipped pixel blend unit. No dependencies.
`timescale 1ns / 1ps

package cpbu_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int OFFSET_BITS_DEF = 28;
    localparam int OFFSET_W        = 28;
    localparam int QUEUE_DEPTH     = 4;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [15:0] ROW_PITCH_RST    = 16'd2560;
    localparam logic [15:0] CLIP_LEFT_RST    = 16'd0;
    localparam logic [15:0] CLIP_TOP_RST     = 16'd0;
    localparam logic [15:0] CLIP_WIDTH_RST   = 16'd640;
    localparam logic [15:0] CLIP_HEIGHT_RST  = 16'd480;

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_GET   = 2'd1,
        FUNC_BLEND = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        FMT_32   = 2'd0,
        FMT_24   = 2'd1,
        FMT_16   = 2'd2,
        FMT_NONE = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_SET   = 2'd1,
        OP_GET   = 2'd2,
        OP_BLEND = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_ROW_PITCH    = 3'd2,
        REG_PIXEL_FORMAT = 3'd3,
        REG_CLIP_LEFT    = 3'd4,
        REG_CLIP_TOP     = 3'd5,
        REG_CLIP_WIDTH   = 3'd6,
        REG_CLIP_HEIGHT  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic in_bounds;
        op_t  op;
        fmt_t fmt;
    } ctl_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [7:0]  alpha;
        logic [15:0] pitch;
        logic [31:0] src;
        logic [31:0] dst;
    } work_t;

    typedef struct packed {
        logic                inside_res;
        logic                write_enable;
        logic [OFFSET_W-1:0] pixel_offset;
        logic [31:0]         write_data;
        logic [31:0]         read_color;
    } result_t;

    function automatic logic [31:0] pack_color(input logic [31:0] c, input fmt_t fmt);
        logic [31:0] r;
        case (fmt)
            FMT_32:  r = c;
            FMT_24:  r = {8'h00, c[23:0]};
            default: r = {16'h0000, c[23:19], c[15:10], c[7:3]};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] unpack_color(input logic [31:0] raw, input fmt_t fmt);
        logic [31:0] r;
        case (fmt)
            FMT_32:  r = raw;
            FMT_24:  r = {8'h00, raw[23:0]};
            default: r = {8'h00, raw[15:11], 3'b000, raw[10:5], 2'b00, raw[4:0], 3'b000};
        endcase
        return r;
    endfunction

endpackage

/* hdl/clipped_pixel_blend_unit.sv */
// clipped_pixel_blend_unit: top level of the framebuffer pixel access unit.
// Depends on cpbu_pkg, cpbu_queue, cpbu_front and cpbu_back.
`timescale 1ns / 1ps

// Takes one set, get or blend item per clock while full is low and returns one
// result item per clock while pop is high and empty is low. The front checks frame
// and clip bounds and classifies the item as it is pushed, a four-entry queue
// decouples it from the back, and the back does the offset multiply and channel mix
// in one registered stage, then the divide by 255 and format packing into a
// four-entry result queue. An accepted item reaches the result ports through the
// front queue, the multiply stage and the result queue; with pop held high the back
// takes one item per cycle. full rises only when the front queue holds four items.
module clipped_pixel_blend_unit #(
    parameter int COORD_BITS  = cpbu_pkg::COORD_BITS_DEF,
    parameter int OFFSET_BITS = cpbu_pkg::OFFSET_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [cpbu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cpbu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       func,
    input  logic [COORD_BITS-1:0]            pos_x,
    input  logic [COORD_BITS-1:0]            pos_y,
    input  logic [31:0]                      src_color,
    input  logic [7:0]                       alpha,
    input  logic [31:0]                      dst_raw,
    output logic                             empty,
    input  logic                             pop,
    output logic                             inside_res,
    output logic                             write_enable,
    output logic [cpbu_pkg::OFFSET_W-1:0]    pixel_offset,
    output logic [31:0]                      write_data,
    output logic [31:0]                      read_color
);

    localparam int ROW_W   = COORD_BITS - 1;
    localparam int COL_W   = COORD_BITS + 1;
    localparam int WORK_W  = $bits(cpbu_pkg::work_t);
    localparam int MID_W   = WORK_W + ROW_W + COL_W;
    localparam int DEPTH   = cpbu_pkg::QUEUE_DEPTH;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    cpbu_pkg::work_t     front_work;
    logic [ROW_W-1:0]    front_row;
    logic [COL_W-1:0]    front_col;
    logic [MID_W-1:0]    mid_out;
    logic [CNT_W-1:0]    mid_count;
    logic                mid_take;
    cpbu_pkg::work_t     back_work;
    logic [ROW_W-1:0]    back_row;
    logic [COL_W-1:0]    back_col;
    cpbu_pkg::result_t   result;

    cpbu_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .func      (func),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .src_color (src_color),
        .alpha     (alpha),
        .dst_raw   (dst_raw),
        .work      (front_work),
        .row       (front_row),
        .col_term  (front_col)
    );

    assign full = (mid_count == CNT_W'(DEPTH));

    cpbu_queue #(
        .WIDTH (MID_W),
        .DEPTH (DEPTH)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && !full),
        .push_data ({front_work, front_row, front_col}),
        .pop       (mid_take),
        .pop_data  (mid_out),
        .count     (mid_count)
    );

    assign back_work = cpbu_pkg::work_t'(mid_out[MID_W-1 -: WORK_W]);
    assign back_row  = mid_out[COL_W +: ROW_W];
    assign back_col  = mid_out[COL_W-1:0];

    cpbu_back #(
        .COORD_BITS  (COORD_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .OUT_DEPTH   (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_avail   (mid_count != '0),
        .in_work    (back_work),
        .in_row     (back_row),
        .in_col     (back_col),
        .in_take    (mid_take),
        .out_pop    (pop),
        .out_result (result),
        .out_empty  (empty)
    );

    assign inside_res   = result.inside_res;
    assign write_enable = result.write_enable;
    assign pixel_offset = result.pixel_offset;
    assign write_data   = result.write_data;
    assign read_color   = result.read_color;

endmodule

/* hdl/cpbu_queue.sv */
// cpbu_queue: small register queue with occupancy count.
// Depends on nothing; used between front and back and at the result side.
`timescale 1ns / 1ps

module cpbu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];
    assign count    = count_reg;

endmodule

/* hdl/cpbu_front.sv */
// cpbu_front: configuration registers, bounds and clip check, request classify,
// destination unpack and offset operand setup. Depends on cpbu_pkg.
`timescale 1ns / 1ps

module cpbu_front #(
    parameter int COORD_BITS = cpbu_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [cpbu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cpbu_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [1:0]                         func,
    input  logic [COORD_BITS-1:0]              pos_x,
    input  logic [COORD_BITS-1:0]              pos_y,
    input  logic [31:0]                        src_color,
    input  logic [7:0]                         alpha,
    input  logic [31:0]                        dst_raw,
    output cpbu_pkg::work_t                    work,
    output logic [COORD_BITS-2:0]              row,
    output logic [COORD_BITS:0]                col_term
);

    localparam int CMP_W = ((COORD_BITS > 17) ? COORD_BITS : 17) + 1;
    localparam int ROW_W = COORD_BITS - 1;
    localparam int COL_W = COORD_BITS + 1;

    logic [12:0]          frame_width_reg;
    logic [12:0]          frame_height_reg;
    logic [15:0]          row_pitch_reg;
    cpbu_pkg::fmt_t       pixel_format_reg;
    logic [15:0]          clip_left_reg;
    logic [15:0]          clip_top_reg;
    logic [15:0]          clip_width_reg;
    logic [15:0]          clip_height_reg;

    logic signed [CMP_W-1:0] xs;
    logic signed [CMP_W-1:0] ys;
    logic signed [CMP_W-1:0] fw;
    logic signed [CMP_W-1:0] fh;
    logic signed [CMP_W-1:0] cl;
    logic signed [CMP_W-1:0] ct;
    logic signed [CMP_W-1:0] cr;
    logic signed [CMP_W-1:0] cb;
    logic                    in_bounds;
    logic                    access;
    logic [COL_W-1:0]        col_x;
    cpbu_pkg::op_t           op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= cpbu_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= cpbu_pkg::FRAME_HEIGHT_RST;
            row_pitch_reg    <= cpbu_pkg::ROW_PITCH_RST;
            pixel_format_reg <= cpbu_pkg::FMT_32;
            clip_left_reg    <= cpbu_pkg::CLIP_LEFT_RST;
            clip_top_reg     <= cpbu_pkg::CLIP_TOP_RST;
            clip_width_reg   <= cpbu_pkg::CLIP_WIDTH_RST;
            clip_height_reg  <= cpbu_pkg::CLIP_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cpbu_pkg::reg_idx_t'(cfg_index))
                cpbu_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[12:0];
                cpbu_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[12:0];
                cpbu_pkg::REG_ROW_PITCH:    row_pitch_reg    <= cfg_data;
                cpbu_pkg::REG_PIXEL_FORMAT: pixel_format_reg <= cpbu_pkg::fmt_t'(cfg_data[1:0]);
                cpbu_pkg::REG_CLIP_LEFT:    clip_left_reg    <= cfg_data;
                cpbu_pkg::REG_CLIP_TOP:     clip_top_reg     <= cfg_data;
                cpbu_pkg::REG_CLIP_WIDTH:   clip_width_reg   <= cfg_data;
                cpbu_pkg::REG_CLIP_HEIGHT:  clip_height_reg  <= cfg_data;
                default:                    frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // bounds and clip check in a common signed width
    always_comb
    begin
        xs = {{(CMP_W - COORD_BITS){pos_x[COORD_BITS-1]}}, pos_x};
        ys = {{(CMP_W - COORD_BITS){pos_y[COORD_BITS-1]}}, pos_y};
        fw = {{(CMP_W - 13){1'b0}}, frame_width_reg};
        fh = {{(CMP_W - 13){1'b0}}, frame_height_reg};
        cl = {{(CMP_W - 16){clip_left_reg[15]}}, clip_left_reg};
        ct = {{(CMP_W - 16){clip_top_reg[15]}}, clip_top_reg};
        cr = cl + signed'({{(CMP_W - 16){1'b0}}, clip_width_reg});
        cb = ct + signed'({{(CMP_W - 16){1'b0}}, clip_height_reg});
        in_bounds = (xs >= 0) && (xs < fw) && (ys >= 0) && (ys < fh) &&
                    (xs >= cl) && (xs < cr) && (ys >= ct) && (ys < cb);
        access = in_bounds && (pixel_format_reg != cpbu_pkg::FMT_NONE);
    end

    always_comb
    begin
        op = cpbu_pkg::OP_NONE;
        if (access)
        begin
            case (cpbu_pkg::func_t'(func))
                cpbu_pkg::FUNC_SET:   op = cpbu_pkg::OP_SET;
                cpbu_pkg::FUNC_GET:   op = cpbu_pkg::OP_GET;
                cpbu_pkg::FUNC_BLEND:
                begin
                    if (alpha == 8'hFF)
                    begin
                        op = cpbu_pkg::OP_SET;
                    end
                    else if (alpha != 8'h00)
                    begin
                        op = cpbu_pkg::OP_BLEND;
                    end
                end
                default:              op = cpbu_pkg::OP_NONE;
            endcase
        end
    end

    // offset operands, zero when there is no access so the offset comes out zero
    always_comb
    begin
        col_x          = {2'b00, pos_x[ROW_W-1:0]};
        row            = '0;
        col_term       = '0;
        work.pitch     = '0;
        work.ctl.in_bounds = in_bounds;
        work.ctl.op    = op;
        work.ctl.fmt   = pixel_format_reg;
        work.alpha     = alpha;
        work.src       = src_color;
        work.dst       = cpbu_pkg::unpack_color(dst_raw, pixel_format_reg);
        if (access)
        begin
            row = pos_y[ROW_W-1:0];
            case (pixel_format_reg)
                cpbu_pkg::FMT_32:
                begin
                    col_term   = col_x;
                    work.pitch = {2'b00, row_pitch_reg[15:2]};
                end
                cpbu_pkg::FMT_24:
                begin
                    col_term   = (col_x << 1) + col_x;
                    work.pitch = row_pitch_reg;
                end
                default:
                begin
                    col_term   = col_x;
                    work.pitch = {1'b0, row_pitch_reg[15:1]};
                end
            endcase
        end
    end

endmodule

/* hdl/cpbu_back.sv */
// cpbu_back: multiply stage for offset and channel mix, then add, divide by 255,
// pack and result queue. Depends on cpbu_pkg and cpbu_queue.
`timescale 1ns / 1ps

module cpbu_back #(
    parameter int COORD_BITS  = cpbu_pkg::COORD_BITS_DEF,
    parameter int OFFSET_BITS = cpbu_pkg::OFFSET_BITS_DEF,
    parameter int OUT_DEPTH   = cpbu_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_avail,
    input  cpbu_pkg::work_t       in_work,
    input  logic [COORD_BITS-2:0] in_row,
    input  logic [COORD_BITS:0]   in_col,
    output logic                  in_take,
    input  logic                  out_pop,
    output cpbu_pkg::result_t     out_result,
    output logic                  out_empty
);

    localparam int ROW_W  = COORD_BITS - 1;
    localparam int COL_W  = COORD_BITS + 1;
    localparam int PROD_W = ROW_W + 16;
    localparam int BIG_W  = PROD_W + 32;
    localparam int CNT_W  = $clog2(OUT_DEPTH + 1);

    logic                s1_valid_reg;
    cpbu_pkg::ctl_t      s1_ctl_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [31:0]         s1_src_reg;
    logic [31:0]         s1_dst_reg;
    logic [15:0]         s1_mix_reg [3];

    logic [15:0]         mix_sum [3];
    logic [7:0]          inv_alpha;
    logic [CNT_W-1:0]    out_count;
    logic [BIG_W-1:0]    off_sum;
    logic [16:0]         div_tmp [3];
    logic [31:0]         mix_color;
    cpbu_pkg::result_t   res;

    // issue only when the result queue has room for everything in flight
    assign in_take = in_avail &&
                     (({1'b0, out_count} + (CNT_W + 1)'(s1_valid_reg)) <
                      (CNT_W + 1)'(OUT_DEPTH));

    assign inv_alpha = 8'hFF - in_work.alpha;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            mix_sum[ch] = 16'(in_work.src[8*ch +: 8]) * 16'(in_work.alpha) +
                          16'(in_work.dst[8*ch +: 8]) * 16'(inv_alpha);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_ctl_reg  <= in_work.ctl;
            s1_prod_reg <= PROD_W'(in_row) * PROD_W'(in_work.pitch);
            s1_col_reg  <= in_col;
            s1_src_reg  <= in_work.src;
            s1_dst_reg  <= in_work.dst;
            for (int ch = 0; ch < 3; ch++)
            begin
                s1_mix_reg[ch] <= mix_sum[ch];
            end
        end
    end

    // divide by 255 as (v + (v >> 8) + 1) >> 8, exact for v up to 255 * 255
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            div_tmp[ch] = 17'(s1_mix_reg[ch]) + 17'(s1_mix_reg[ch][15:8]) + 17'd1;
        end
        mix_color = {8'h00, div_tmp[2][15:8], div_tmp[1][15:8], div_tmp[0][15:8]};
    end

    always_comb
    begin
        off_sum = BIG_W'(s1_prod_reg) + BIG_W'(s1_col_reg);
        for (int i = 0; i < cpbu_pkg::OFFSET_W; i++)
        begin
            res.pixel_offset[i] = (i < OFFSET_BITS) ? off_sum[i] : 1'b0;
        end
        res.inside_res   = s1_ctl_reg.in_bounds;
        res.write_enable = 1'b0;
        res.write_data   = '0;
        res.read_color   = '0;
        case (s1_ctl_reg.op)
            cpbu_pkg::OP_SET:
            begin
                res.write_enable = 1'b1;
                res.write_data   = cpbu_pkg::pack_color(s1_src_reg, s1_ctl_reg.fmt);
            end
            cpbu_pkg::OP_BLEND:
            begin
                res.write_enable = 1'b1;
                res.write_data   = cpbu_pkg::pack_color(mix_color, s1_ctl_reg.fmt);
            end
            cpbu_pkg::OP_GET:
            begin
                res.read_color = s1_dst_reg;
            end
            default:
            begin
                res.write_enable = 1'b0;
            end
        endcase
    end

    cpbu_queue #(
        .WIDTH ($bits(cpbu_pkg::result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (res),
        .pop       (out_pop && !out_empty),
        .pop_data  (out_result),
        .count     (out_count)
    );

    assign out_empty = (out_count == '0);

endmodule
